>>> design/rcfu_pkg.sv
// Shared constants and types for the RC frame channel unpacker.
// No dependencies; used by rc_frame_channel_unpacker_top.

package rcfu_pkg;

    localparam int unsigned FrameBytes   = 26;
    localparam int unsigned PayloadFirst = 3;
    localparam int unsigned TypePos      = 2;
    localparam int unsigned ChannelBits  = 11;
    localparam int unsigned ChannelCount = 16;
    localparam int unsigned AccBits      = 18;

    localparam logic [7:0] SyncByteReset  = 8'hC8;
    localparam logic [7:0] FrameTypeReset = 8'h16;

    localparam int unsigned AddrBits = 3;

    // Register index as decoded from paddr[2].
    typedef enum logic [0:0] {
        REG_SYNC_BYTE  = 1'b0,
        REG_FRAME_TYPE = 1'b1
    } reg_index_t;

endpackage

>>> design/rc_frame_channel_unpacker_top.sv
// RC frame channel unpacker: hunts for sync, collects 26-byte frames and
// unpacks sixteen 11-bit channels from those of the set type. Depends on rcfu_pkg.
//
// Throughput: one received byte per cycle. The sixteen channel transfers of a
// frame start the cycle after its last byte is taken, one per cycle while
// out_stall is low, from a 16-entry output buffer; a frame's last byte waits
// only while the previous frame's burst is still draining.
// Reset (rst_n, async, active low) returns to hunting with registers at 200/22.

module rc_frame_channel_unpacker_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  channel_index,
    output logic [10:0] channel_value,
    output logic        last_channel,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [rcfu_pkg::AddrBits-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned PosBits = 5;
    localparam int unsigned IdxBits = 4;
    localparam int unsigned CntBits = 5;
    localparam int unsigned HeldBits = 5;

    localparam logic [PosBits-1:0] PosType    = PosBits'(rcfu_pkg::TypePos);
    localparam logic [PosBits-1:0] PosPayload = PosBits'(rcfu_pkg::PayloadFirst);
    localparam logic [PosBits-1:0] PosLast    = PosBits'(rcfu_pkg::FrameBytes - 1);
    localparam logic [PosBits-1:0] PosEnd     = PosBits'(rcfu_pkg::FrameBytes);
    localparam logic [IdxBits-1:0] IdxLast    = IdxBits'(rcfu_pkg::ChannelCount - 1);
    localparam logic [CntBits-1:0] CntFull    = CntBits'(rcfu_pkg::ChannelCount);
    localparam logic [HeldBits-1:0] HeldChan  = HeldBits'(rcfu_pkg::ChannelBits);

    // Configuration registers
    logic [7:0] sync_byte_reg;
    logic [7:0] frame_type_reg;

    // Frame tracking and unpacking state
    logic [PosBits-1:0]              pos_reg, pos_next;
    logic                            match_reg, match_next;
    logic [rcfu_pkg::AccBits-1:0]    acc_reg, acc_next;
    logic [HeldBits-1:0]             held_reg, held_next;
    logic [CntBits-1:0]              done_reg, done_next;

    // Working store and the output buffer that a finished frame is copied into
    logic [rcfu_pkg::ChannelBits-1:0] store_reg [rcfu_pkg::ChannelCount];
    logic [rcfu_pkg::ChannelBits-1:0] obuf_reg  [rcfu_pkg::ChannelCount];

    logic               emit_active_reg, emit_active_next;
    logic [IdxBits-1:0] emit_idx_reg, emit_idx_next;

    logic in_take;
    logic out_take;
    logic emit_busy;
    logic frame_end;
    logic payload_pos;
    logic store_we;
    logic [rcfu_pkg::ChannelBits-1:0] store_wdata;

    logic [22:0]                   shifted;
    logic [rcfu_pkg::AccBits-1:0]  acc_sum;
    logic [HeldBits-1:0]           held_sum;

    logic cfg_write;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign out_take  = emit_active_reg && !out_stall;
    // The burst buffer is free next cycle unless a burst is active and its last channel is not taken now.
    assign emit_busy = emit_active_reg && !(out_take && (emit_idx_reg == IdxLast));
    assign in_stall  = (pos_reg == PosLast) && emit_busy;
    assign in_take   = in_valid && !in_stall;

    assign out_valid     = emit_active_reg;
    assign channel_index = emit_idx_reg;
    assign channel_value = obuf_reg[emit_idx_reg];
    assign last_channel  = (emit_idx_reg == IdxLast);

    // ------------------------------------------------------------------
    // Frame tracking and bit unpacking
    // ------------------------------------------------------------------
    assign payload_pos = (pos_reg >= PosPayload) && (pos_reg < PosLast);
    assign frame_end   = in_take && (pos_reg == PosLast);

    always_comb
    begin
        shifted  = {15'b0, rx_byte} << held_reg[3:0];
        acc_sum  = acc_reg | shifted[rcfu_pkg::AccBits-1:0];
        held_sum = held_reg + HeldBits'(8);

        pos_next    = pos_reg;
        match_next  = match_reg;
        acc_next    = acc_reg;
        held_next   = held_reg;
        done_next   = done_reg;
        store_we    = 1'b0;
        store_wdata = acc_sum[rcfu_pkg::ChannelBits-1:0];

        if (in_take)
        begin
            if ((pos_reg == '0) || (pos_reg >= PosEnd))
            begin
                pos_next = (rx_byte == sync_byte_reg) ? PosBits'(1) : '0;
            end
            else if (pos_reg == PosLast)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + PosBits'(1);
                if (pos_reg == PosType)
                begin
                    match_next = (rx_byte == frame_type_reg);
                    acc_next   = '0;
                    held_next  = '0;
                    done_next  = '0;
                end
                else if (payload_pos && match_reg)
                begin
                    acc_next  = acc_sum;
                    held_next = held_sum;
                    if (held_sum >= HeldChan)
                    begin
                        if (done_reg < CntFull)
                        begin
                            store_we  = 1'b1;
                            done_next = done_reg + CntBits'(1);
                        end
                        acc_next  = acc_sum >> rcfu_pkg::ChannelBits;
                        held_next = held_sum - HeldChan;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Burst emission
    // ------------------------------------------------------------------
    always_comb
    begin
        emit_active_next = emit_active_reg;
        emit_idx_next    = emit_idx_reg;
        if (out_take)
        begin
            if (emit_idx_reg == IdxLast)
            begin
                emit_active_next = 1'b0;
            end
            else
            begin
                emit_idx_next = emit_idx_reg + IdxBits'(1);
            end
        end
        if (frame_end && match_reg)
        begin
            emit_active_next = 1'b1;
            emit_idx_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            match_reg       <= 1'b0;
            acc_reg         <= '0;
            held_reg        <= '0;
            done_reg        <= '0;
            emit_active_reg <= 1'b0;
            emit_idx_reg    <= '0;
        end
        else
        begin
            pos_reg         <= pos_next;
            match_reg       <= match_next;
            acc_reg         <= acc_next;
            held_reg        <= held_next;
            done_reg        <= done_next;
            emit_active_reg <= emit_active_next;
            emit_idx_reg    <= emit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[done_reg[IdxBits-1:0]] <= store_wdata;
        end
        if (frame_end && match_reg)
        begin
            obuf_reg <= store_reg;
        end
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg  <= rcfu_pkg::SyncByteReset;
            frame_type_reg <= rcfu_pkg::FrameTypeReset;
        end
        else if (cfg_write)
        begin
            case (rcfu_pkg::reg_index_t'(paddr[2]))
                rcfu_pkg::REG_SYNC_BYTE:  sync_byte_reg  <= pwdata[7:0];
                rcfu_pkg::REG_FRAME_TYPE: frame_type_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (rcfu_pkg::reg_index_t'(paddr[2]))
            rcfu_pkg::REG_SYNC_BYTE:  prdata = {24'b0, sync_byte_reg};
            rcfu_pkg::REG_FRAME_TYPE: prdata = {24'b0, frame_type_reg};
            default:                  prdata = '0;
        endcase
    end

endmodule

>>> tb/channel_frame_checker.sv
// Checker for the RC frame channel unpacker: follows register writes and received
// bytes, predicts the channel transfers and compares them with the output channel.
// Depends on rcfu_pkg.
`timescale 1ns / 100ps

module channel_frame_checker
    import rcfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  channel_index,
    input  logic [10:0] channel_value,
    input  logic        last_channel,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [AddrBits-1:0] paddr,
    input  logic [31:0] pwdata,

    output int          errors,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic [3:0]  idx;
        logic [10:0] value;
        logic        is_last;
    } channel_transfer_t;

    channel_transfer_t expected_channels[$];

    logic [7:0]         sync_cfg;
    logic [7:0]         type_cfg;
    logic [4:0]         frame_pos;
    logic               type_ok;
    logic [AccBits-1:0] acc;
    logic [4:0]         acc_bits;
    logic [4:0]         chans_done;
    logic [10:0]        chan_store [ChannelCount];

    initial
    begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    // Advances the frame tracker by one received byte and queues the sixteen
    // channel transfers when a frame of the selected type completes.
    task automatic unpack_rx_byte(input logic [7:0] b);
        logic [31:0]       merged;
        channel_transfer_t t;
        int                k;
        if (frame_pos == 0 || frame_pos >= FrameBytes) begin
            frame_pos = (b == sync_cfg) ? 5'd1 : 5'd0;
        end else if (frame_pos == FrameBytes - 1) begin
            if (type_ok) begin
                for (k = 0; k < ChannelCount; k++) begin
                    t.idx     = k[3:0];
                    t.value   = chan_store[k];
                    t.is_last = (k == ChannelCount - 1);
                    expected_channels.push_back(t);
                end
            end
            frame_pos = 5'd0;
        end else begin
            if (frame_pos == TypePos) begin
                type_ok    = (b == type_cfg);
                acc        = '0;
                acc_bits   = 5'd0;
                chans_done = 5'd0;
            end else if (frame_pos >= PayloadFirst && type_ok) begin
                merged   = {14'b0, acc} | ({24'b0, b} << (acc_bits & 5'd15));
                acc      = merged[AccBits-1:0];
                acc_bits = acc_bits + 5'd8;
                if (acc_bits >= ChannelBits) begin
                    if (chans_done < ChannelCount) begin
                        chan_store[chans_done[3:0]] = acc[ChannelBits-1:0];
                        chans_done = chans_done + 5'd1;
                    end
                    acc      = acc >> ChannelBits;
                    acc_bits = acc_bits - 5'(ChannelBits);
                end
            end
            frame_pos = frame_pos + 5'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        channel_transfer_t exp_ch;
        if (!rst_n) begin
            sync_cfg   = SyncByteReset;
            type_cfg   = FrameTypeReset;
            frame_pos  = 5'd0;
            type_ok    = 1'b0;
            acc        = '0;
            acc_bits   = 5'd0;
            chans_done = 5'd0;
            expected_channels.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[2]))
                    REG_SYNC_BYTE:  sync_cfg = pwdata[7:0];
                    REG_FRAME_TYPE: type_cfg = pwdata[7:0];
                    default: ;
                endcase
            end

            // Outputs are checked before the input of the same edge is predicted,
            // since a transfer never stems from a byte taken at the same edge.
            if (out_valid && !out_stall) begin
                if (expected_channels.size() == 0) begin
                    errors++;
                    $error("unexpected channel transfer: index %0d value %0d last %0d",
                           channel_index, channel_value, last_channel);
                end else begin
                    exp_ch = expected_channels.pop_front();
                    checked++;
                    if (channel_index !== exp_ch.idx) begin
                        errors++;
                        $error("channel_index mismatch: expected %0d, actual %0d",
                               exp_ch.idx, channel_index);
                    end
                    if (channel_value !== exp_ch.value) begin
                        errors++;
                        $error("channel_value mismatch: expected %0d, actual %0d",
                               exp_ch.value, channel_value);
                    end
                    if (last_channel !== exp_ch.is_last) begin
                        errors++;
                        $error("last_channel mismatch: expected %0d, actual %0d",
                               exp_ch.is_last, last_channel);
                    end
                end
            end

            if (in_valid && !in_stall)
                unpack_rx_byte(rx_byte);
        end
        pending = expected_channels.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the RC frame channel unpacker testbench: clock, reset, byte and register
// stimulus, output stall, watchdog and verdict. Depends on rcfu_pkg,
// rc_frame_channel_unpacker_top and channel_frame_checker.
`timescale 1ns / 100ps

module testbench;
    import rcfu_pkg::*;

    localparam int HoldCycles    = 150;
    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        last_channel;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [AddrBits-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int checked;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int bytes_sent = 0;
    int frames_sent = 0;

    logic [7:0] sync_val = SyncByteReset;
    logic [7:0] type_val = FrameTypeReset;

    rc_frame_channel_unpacker_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last_channel  (last_channel),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    channel_frame_checker frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last_channel  (last_channel),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked)
    );

    always #1 clk = ~clk;

    // Receiver side: random stall, or a long hold-off each time one is requested.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HoldCycles;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("no transfer for %0d cycles, %0d channels outstanding",
                     idle_cycles, pending);
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        do
            b = 8'($urandom_range(255));
        while (b == sync_val);
        return b;
    endfunction

    function automatic logic [10:0] random_channel();
        case ($urandom_range(7))
            0:       return 11'h000;
            1:       return 11'h7FF;
            default: return 11'($urandom_range(2047));
        endcase
    endfunction

    // Sends one complete frame; pattern 0 is random, 1 alternates zero and full scale.
    task automatic send_frame(input logic type_match, input int pattern);
        logic [175:0] packed_bits;
        logic [7:0]   t;
        int           i;
        for (i = 0; i < ChannelCount; i++)
            packed_bits[i*ChannelBits +: ChannelBits] =
                (pattern == 1) ? (i[0] ? 11'h7FF : 11'h000) : random_channel();
        if (type_match)
        begin
            t = type_val;
        end
        else
        begin
            do
                t = 8'($urandom_range(255));
            while (t == type_val);
        end
        send_byte(sync_val);
        send_byte(8'd24);
        send_byte(t);
        for (i = 0; i < 22; i++)
            send_byte(packed_bits[i*8 +: 8]);
        send_byte(8'($urandom_range(255)));
        frames_sent++;
    endtask

    // Mostly well-formed frames, some of another type, some cut short after sync.
    task automatic send_random_frames(input int count);
        int n;
        int k;
        int sel;
        for (n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                send_frame(1'b1, 0);
            end
            else if (sel < 85)
            begin
                send_frame(1'b0, 0);
            end
            else
            begin
                send_byte(sync_val);
                for (k = $urandom_range(24); k > 0; k--)
                    send_byte(8'($urandom_range(255)));
            end
            for (k = $urandom_range(3); k > 0; k--)
                send_byte(noise_byte());
        end
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t r, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {24'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (r == REG_SYNC_BYTE)
            sync_val = v;
        else
            type_val = v;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bytes skipped while hunting, then a frame of extreme channels.
        send_idle_pct = 13;
        recv_idle_pct = 78;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(1'b1, 1);
        wait_for_drain();

        write_reg(REG_SYNC_BYTE, 8'h00);
        write_reg(REG_FRAME_TYPE, 8'hFF);
        send_random_frames(3);
        wait_for_drain();

        send_idle_pct = 78;
        recv_idle_pct = 13;
        write_reg(REG_SYNC_BYTE, 8'hFF);
        write_reg(REG_FRAME_TYPE, 8'h00);
        send_random_frames(3);
        wait_for_drain();

        // No idling; the receiver holds off long enough to back up the input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_SYNC_BYTE, 8'($urandom_range(255)));
        write_reg(REG_FRAME_TYPE, 8'($urandom_range(255)));
        hold_token = hold_token + 1;
        send_frame(1'b1, 0);
        send_frame(1'b1, 0);
        send_random_frames(2);

        wait_for_drain();
        repeat (20) @(posedge clk);

        $display("summary: %0d bytes in %0d complete frames under four register settings,",
                 bytes_sent, frames_sent);
        $display("summary: %0d channel transfers compared, %0d mismatches", checked, errors);
        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
